/* rtl/core/ifp_pkg.sv */
// Shared types, character codes and helper functions of the infix to postfix converter.
package ifp_pkg;

	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_OVER  = 2'd1,
		ERR_UNDER = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		SEL_CHAR = 2'd0,
		SEL_TOP  = 2'd1,
		SEL_ZERO = 2'd2
	} sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROC,
		ST_FLUSH,
		ST_ERR_OVER,
		ST_ERR_UNDER
	} state_t;

	typedef struct packed {
		logic load;
		logic push;
		logic pop;
		logic emit;
		sel_t sel;
		logic end_flag;
		err_t err;
		logic finish;
		logic clr_count;
		logic set_skip;
		logic clr_skip;
	} dp_cmd_t;

	typedef struct packed {
		logic is_alnum;
		logic is_lparen;
		logic is_rparen;
		logic last;
		logic skip;
		logic empty;
		logic full;
		logic top_lparen;
		logic top_yields;
		logic hold_v;
		logic out_free;
	} dp_sts_t;

	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		case (c)
			CH_CARET: p = 2'd3;
			CH_STAR, CH_SLASH: p = 2'd2;
			CH_PLUS, CH_MINUS: p = 2'd1;
			default: p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

endpackage

/* rtl/core/ifp_dpath.sv */
// Datapath: operator stack memory, stack count, hold slot and output register.
module ifp_dpath #(
	parameter int STACK_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_char,
	input  logic             last_char,
	input  ifp_pkg::dp_cmd_t cmd,
	output ifp_pkg::dp_sts_t sts,
	output logic             dst_valid,
	input  logic             dst_stall,
	output logic [7:0]       out_char,
	output logic             run_last,
	output logic             expr_end,
	output logic [1:0]       error_code
);
	import ifp_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [7:0]    mem [STACK_DEPTH];
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] rd_full;
	logic [AW-1:0] rd_addr;
	logic          skip_q;
	logic [7:0]    ch_q;
	logic          last_q;
	logic [7:0]    top_q;
	logic          hold_v_q;
	logic [7:0]    hold_char_q;
	logic          hold_end_q;
	err_t          hold_err_q;
	logic          out_v_q;
	logic [7:0]    out_char_q;
	logic          run_last_q;
	logic          expr_end_q;
	err_t          out_err_q;
	logic          out_free;
	logic          move;
	logic [7:0]    emit_char;
	logic [1:0]    prec_top;
	logic [1:0]    prec_in;

	always_comb begin
		if (cmd.clr_count) begin
			count_d = '0;
		end else if (cmd.push) begin
			count_d = count_q + CW'(1);
		end else if (cmd.pop) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	assign rd_full = count_d - CW'(1);
	assign rd_addr = rd_full[AW-1:0];

	// The top of stack is kept in a register; each cycle it is refreshed from the
	// entry that will be on top next cycle, unless the stack is left empty.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[count_q[AW-1:0]] <= ch_q;
			top_q <= ch_q;
		end else if (count_d != '0) begin
			top_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			skip_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.set_skip) begin
				skip_q <= 1'b1;
			end else if (cmd.clr_skip) begin
				skip_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q <= in_char;
			last_q <= last_char;
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_CHAR: emit_char = ch_q;
			SEL_TOP: emit_char = top_q;
			default: emit_char = 8'h00;
		endcase
	end

	// A result waits in the hold slot until the next one arrives or the word
	// ends, so the final result of a word can be marked on its way out.
	assign out_free = !out_v_q || !dst_stall;
	assign move = hold_v_q && (cmd.emit || cmd.finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				hold_v_q <= 1'b1;
			end else if (cmd.finish) begin
				hold_v_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (!dst_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hold_char_q <= emit_char;
			hold_end_q <= cmd.end_flag;
			hold_err_q <= cmd.err;
		end
		if (move) begin
			out_char_q <= hold_char_q;
			run_last_q <= cmd.finish;
			expr_end_q <= hold_end_q;
			out_err_q <= hold_err_q;
		end
	end

	assign prec_top = prec_of(top_q);
	assign prec_in = prec_of(ch_q);

	always_comb begin
		sts = '0;
		sts.is_alnum = is_alnum(ch_q);
		sts.is_lparen = (ch_q == CH_LPAREN);
		sts.is_rparen = (ch_q == CH_RPAREN);
		sts.last = last_q;
		sts.skip = skip_q;
		sts.empty = (count_q == '0);
		sts.full = (count_q == CW'(STACK_DEPTH));
		sts.top_lparen = (top_q == CH_LPAREN);
		sts.top_yields = (prec_top > prec_in) || (prec_top == prec_in && ch_q != CH_CARET);
		sts.hold_v = hold_v_q;
		sts.out_free = out_free;
	end

	assign dst_valid = out_v_q;
	assign out_char = out_char_q;
	assign run_last = run_last_q;
	assign expr_end = expr_end_q;
	assign error_code = out_err_q;

endmodule

/* rtl/core/ifp_ctrl.sv */
// Controller: sequences one character at a time through the stack datapath.
module ifp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	output logic             src_stall,
	input  ifp_pkg::dp_sts_t sts,
	output ifp_pkg::dp_cmd_t cmd
);
	import ifp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   can_emit;
	state_t after_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign can_emit = !sts.hold_v || sts.out_free;
	assign after_st = sts.last ? ST_FLUSH : ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		src_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				// The pending result of the previous word leaves here as its last one.
				src_stall = sts.hold_v && !sts.out_free;
				cmd.finish = sts.hold_v && sts.out_free;
				if (src_valid && !src_stall) begin
					cmd.load = 1'b1;
					state_d = ST_PROC;
				end
			end
			ST_PROC: begin
				if (sts.skip) begin
					cmd.clr_skip = sts.last;
					state_d = ST_IDLE;
				end else if (sts.is_alnum) begin
					if (can_emit) begin
						cmd.emit = 1'b1;
						cmd.sel = SEL_CHAR;
						state_d = after_st;
					end
				end else if (sts.is_lparen) begin
					if (sts.full) begin
						state_d = ST_ERR_OVER;
					end else begin
						cmd.push = 1'b1;
						state_d = after_st;
					end
				end else if (sts.is_rparen) begin
					if (sts.empty) begin
						state_d = ST_ERR_UNDER;
					end else if (sts.top_lparen) begin
						cmd.pop = 1'b1;
						state_d = after_st;
					end else if (can_emit) begin
						cmd.emit = 1'b1;
						cmd.sel = SEL_TOP;
						cmd.pop = 1'b1;
					end
				end else begin
					if (!sts.empty && !sts.top_lparen && sts.top_yields) begin
						if (can_emit) begin
							cmd.emit = 1'b1;
							cmd.sel = SEL_TOP;
							cmd.pop = 1'b1;
						end
					end else if (sts.full) begin
						state_d = ST_ERR_OVER;
					end else begin
						cmd.push = 1'b1;
						state_d = after_st;
					end
				end
			end
			ST_FLUSH: begin
				if (can_emit) begin
					cmd.emit = 1'b1;
					if (!sts.empty) begin
						cmd.sel = SEL_TOP;
						cmd.pop = 1'b1;
					end else begin
						cmd.sel = SEL_ZERO;
						cmd.end_flag = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR_OVER, ST_ERR_UNDER: begin
				if (can_emit) begin
					cmd.emit = 1'b1;
					cmd.sel = SEL_ZERO;
					cmd.end_flag = 1'b1;
					cmd.err = (state_q == ST_ERR_OVER) ? ERR_OVER : ERR_UNDER;
					cmd.clr_count = 1'b1;
					cmd.set_skip = !sts.last;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/infix_to_postfix_converter_top.sv */
// Top level of the infix to postfix converter: controller, datapath and checks.
//
// Converts an infix expression, one ASCII character per input word, into postfix
// form, one character per output word, using an operator stack of STACK_DEPTH
// entries. Each input word is accepted in ST_IDLE, then processed in ST_PROC, which
// pops the operators it releases; on the final character ST_FLUSH pops the rest
// and emits the terminator word. The stack memory delivers one new top entry per
// cycle while the output is free to take it. The last output word of
// each input word carries run_last; the word that ends an expression carries
// expr_end and, after a stack overflow or unmatched ')', a nonzero error_code,
// after which input is dropped up to the next final character. No clearing pass
// is needed after reset.
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] in_char,
	input  logic       last_char,
	output logic       dst_valid,
	input  logic       dst_stall,
	output logic [7:0] out_char,
	output logic       run_last,
	output logic       expr_end,
	output logic [1:0] error_code
);
	import ifp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	ifp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ifp_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_char    (in_char),
		.last_char  (last_char),
		.cmd        (cmd),
		.sts        (sts),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.out_char   (out_char),
		.run_last   (run_last),
		.expr_end   (expr_end),
		.error_code (error_code)
	);

`ifndef ASSERT_OFF
	// A terminator or error word is always the last word of its input word and
	// carries no character.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && expr_end) |-> (run_last && out_char == 8'h00))
		else $error("expression end word not marked last or carries a character");

	// Error codes only appear on the word that ends the expression.
	a_err_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && error_code != ERR_NONE) |-> expr_end)
		else $error("error code on a character word");

	// Once a word is taken, the block is busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall) |=> src_stall)
		else $error("input taken on two consecutive cycles");

	// The stack count never reports empty and full at once.
	a_count_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.empty && sts.full))
		else $error("stack count inconsistent");
`endif

endmodule

/* verif/infix_to_postfix_converter_top_tb.sv */
// Self-checking testbench of the infix to postfix converter with a shunting-yard predictor.
module infix_to_postfix_converter_top_tb;
	import ifp_pkg::*;

	localparam int DEPTH = 32;
	localparam int N_DIRECTED = 24;
	localparam int N_RANDOM = 480;
	localparam int DRAIN_CYCLES = 80;
	localparam longint CYCLE_LIMIT = 5_000_000;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_last;
		logic       expr_end;
		logic [1:0] err;
	} postfix_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	logic [7:0] in_char = 8'd0;
	logic       last_char = 1'b0;
	logic       dst_valid;
	logic       dst_stall = 1'b0;
	logic [7:0] out_char;
	logic       run_last;
	logic       expr_end;
	logic [1:0] error_code;

	char_word_t    pending[$];
	postfix_word_t postfix_due[$];
	logic [7:0]    expr_buf[$];

	// Predictor state: operator stack, its fill level and the drop-after-error flag.
	logic [7:0] opstk [DEPTH];
	int         opstk_cnt = 0;
	logic       drop_rest = 1'b0;

	int     fails = 0;
	int     src_gap = 0;
	logic   src_burst = 1'b0;
	int     stall_left = 0;
	logic   dst_burst = 1'b0;
	longint cycles = 0;

	infix_to_postfix_converter_top #(
		.STACK_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.in_char(in_char),
		.last_char(last_char),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.out_char(out_char),
		.run_last(run_last),
		.expr_end(expr_end),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	function automatic logic is_operand(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [1:0] op_rank(input logic [7:0] c);
		if (c == CH_CARET) return 2'd3;
		if (c == CH_STAR || c == CH_SLASH) return 2'd2;
		if (c == CH_PLUS || c == CH_MINUS) return 2'd1;
		return 2'd0;
	endfunction

	function automatic postfix_word_t char_word(input logic [7:0] c);
		postfix_word_t w;
		w.ch = c;
		w.run_last = 1'b0;
		w.expr_end = 1'b0;
		w.err = ERR_NONE;
		return w;
	endfunction

	function automatic logic push_op(input logic [7:0] c);
		if (opstk_cnt >= DEPTH) return 1'b0;
		opstk[opstk_cnt] = c;
		opstk_cnt++;
		return 1'b1;
	endfunction

	// Advances the predictor by one accepted character and queues the words it emits.
	task automatic shunt_char(input logic [7:0] c, input logic last);
		postfix_word_t words[$];
		postfix_word_t w;
		err_t          err;
		logic [1:0]    pc;
		logic [7:0]    t;
		err = ERR_NONE;
		if (drop_rest) begin
			if (last) drop_rest = 1'b0;
			return;
		end
		if (is_operand(c)) begin
			words.push_back(char_word(c));
		end else if (c == CH_LPAREN) begin
			if (!push_op(c)) err = ERR_OVER;
		end else if (c == CH_RPAREN) begin
			while (opstk_cnt > 0 && opstk[opstk_cnt - 1] != CH_LPAREN) begin
				opstk_cnt--;
				words.push_back(char_word(opstk[opstk_cnt]));
			end
			if (opstk_cnt == 0) err = ERR_UNDER;
			else opstk_cnt--;
		end else begin
			pc = op_rank(c);
			while (opstk_cnt > 0) begin
				t = opstk[opstk_cnt - 1];
				if (t == CH_LPAREN) break;
				// Caret is right-associative, so an equal rank only yields to other operators.
				if (!(op_rank(t) > pc || (op_rank(t) == pc && c != CH_CARET))) break;
				opstk_cnt--;
				words.push_back(char_word(t));
			end
			if (!push_op(c)) err = ERR_OVER;
		end
		if (err != ERR_NONE) begin
			w = char_word(8'd0);
			w.expr_end = 1'b1;
			w.err = err;
			words.push_back(w);
			opstk_cnt = 0;
			if (!last) drop_rest = 1'b1;
		end else if (last) begin
			while (opstk_cnt > 0) begin
				opstk_cnt--;
				words.push_back(char_word(opstk[opstk_cnt]));
			end
			w = char_word(8'd0);
			w.expr_end = 1'b1;
			words.push_back(w);
		end
		if (words.size() > 0) words[words.size() - 1].run_last = 1'b1;
		foreach (words[i]) postfix_due.push_back(words[i]);
	endtask

	function automatic int pick_gap(input logic burst);
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 80) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_operand();
		int r;
		r = $urandom_range(0, 61);
		if (r < 10) return 8'(32'h30 + r);
		if (r < 36) return 8'(32'h41 + (r - 10));
		return 8'(32'h61 + (r - 36));
	endfunction

	function automatic logic [7:0] pick_op();
		logic [7:0] c;
		case ($urandom_range(0, 11))
			0, 1: c = CH_PLUS;
			2, 3: c = CH_MINUS;
			4, 5: c = CH_STAR;
			6: c = CH_SLASH;
			7, 8, 9: c = CH_CARET;
			default: begin
				c = 8'($urandom_range(0, 255));
				while (is_operand(c) || c == CH_LPAREN || c == CH_RPAREN)
					c = 8'($urandom_range(0, 255));
			end
		endcase
		return c;
	endfunction

	task automatic build_expr(input int depth);
		int n_ops;
		n_ops = $urandom_range(0, 3);
		build_operand(depth);
		for (int i = 0; i < n_ops; i++) begin
			expr_buf.push_back(pick_op());
			build_operand(depth);
		end
	endtask

	task automatic build_operand(input int depth);
		if (depth > 0 && $urandom_range(0, 3) == 0) begin
			expr_buf.push_back(CH_LPAREN);
			build_expr(depth - 1);
			expr_buf.push_back(CH_RPAREN);
		end else begin
			expr_buf.push_back(pick_operand());
		end
	endtask

	// Deep nesting: n pushes of '(' or '^', an operand, then a number of ')'.
	task automatic build_nest(input int n, input int closes);
		for (int i = 0; i < n; i++)
			expr_buf.push_back(($urandom_range(0, 5) == 0) ? CH_CARET : CH_LPAREN);
		expr_buf.push_back(pick_operand());
		for (int i = 0; i < closes; i++) expr_buf.push_back(CH_RPAREN);
	endtask

	// Moves the buffered expression to the pending words, last flag on its final character.
	task automatic flush_buf();
		char_word_t w;
		foreach (expr_buf[i]) begin
			w.ch = expr_buf[i];
			w.last = (i == expr_buf.size() - 1);
			pending.push_back(w);
		end
		expr_buf.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
		flush_buf();
	endtask

	always @(posedge clk) begin
		logic       nxt_valid;
		char_word_t w;
		if (arst_n) begin
			nxt_valid = src_valid;
			if (src_valid && !src_stall) begin
				shunt_char(in_char, last_char);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending.size() > 0) begin
					w = pending.pop_front();
					in_char <= w.ch;
					last_char <= w.last;
					nxt_valid = 1'b1;
					src_gap = pick_gap(src_burst);
					if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
				end
			end
			src_valid <= nxt_valid;
		end
	end

	always @(posedge clk) begin
		postfix_word_t got;
		postfix_word_t want;
		if (arst_n) begin
			if (dst_valid && !dst_stall) begin
				got = '{out_char, run_last, expr_end, error_code};
				if (postfix_due.size() == 0) begin
					$display("%0t: unexpected word char=%h run_last=%b end=%b err=%0d",
						$time, got.ch, got.run_last, got.expr_end, got.err);
					fails++;
				end else begin
					want = postfix_due.pop_front();
					if (got !== want) begin
						$display("%0t: expected %h %b %b %0d, actual %h %b %b %0d",
							$time, want.ch, want.run_last, want.expr_end, want.err,
							got.ch, got.run_last, got.expr_end, got.err);
						fails++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				dst_stall <= 1'b1;
			end else begin
				dst_stall <= 1'b0;
				if (!dst_burst && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
				if ($urandom_range(0, 199) == 0) dst_burst = !dst_burst;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int kind;
		int pos;
		// Precedence, right-associative caret, parentheses.
		add_text("a+b*c");
		add_text("(A-9)^2^z");
		// Zero and high bytes as operators; an unmatched '(' flushed on the final character.
		expr_buf = '{8'h00, "q", 8'hFF, CH_SLASH, CH_LPAREN};
		flush_buf();
		// Underflow before the end drops the rest; underflow on the final character.
		add_text(")k");
		add_text("b+)");
		// Overflow on the final character, overflow mid-expression, a full stack flushed.
		repeat (DEPTH + 1) expr_buf.push_back(CH_LPAREN);
		flush_buf();
		build_nest(DEPTH + 1, 0);
		flush_buf();
		for (int i = 0; i < DEPTH; i++) expr_buf.push_back(CH_LPAREN);
		expr_buf.push_back("a");
		flush_buf();
		while (pending.size() < N_DIRECTED + N_RANDOM) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				build_expr($urandom_range(0, 3));
			end else if (kind < 80) begin
				build_expr(2);
				pos = $urandom_range(0, expr_buf.size());
				expr_buf.insert(pos, ($urandom_range(0, 1) == 0) ? CH_RPAREN : CH_LPAREN);
			end else if (kind < 88) begin
				build_nest($urandom_range(DEPTH - 8, DEPTH + 4), $urandom_range(0, DEPTH + 4));
			end else begin
				repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
			end
			flush_buf();
		end
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (!(pending.size() == 0 && !src_valid && postfix_due.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (postfix_due.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, postfix_due.size());
			fails++;
		end
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
